// ===== rtl/sfc_pkg.sv =====
// Shared types and constants for the serial frame checker.
package sfc_pkg;

   // Frame layout
   localparam int FRAME_BYTES   = 17;
   localparam int PAYLOAD_BYTES = 12;
   localparam int CMD_OFFSET    = 3;
   localparam int CRC_BYTES     = 4;
   localparam int POS_W         = $clog2(FRAME_BYTES + 2);

   // CRC-32 (non-reflected, no final XOR)
   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Register reset values
   localparam logic [7:0] START_MARKER_RST  = 8'h24;
   localparam logic [7:0] END_MARKER_RST    = 8'hFD;
   localparam logic [7:0] COMMAND_LIMIT_RST = 8'h07;

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MARKER  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_LIMIT = 8'd2;

   typedef enum logic [1:0] {
      VERDICT_GOOD     = 2'd0,
      VERDICT_TOO_LONG = 2'd1,
      VERDICT_BAD_FMT  = 2'd2,
      VERDICT_CRC_BAD  = 2'd3
   } sfc_verdict_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } sfc_req_type;

   typedef struct packed {
      sfc_verdict_type verdict;
      logic [7:0]      command;
      logic            dispatch;
   } sfc_rsp_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] command_limit;
   } sfc_cfg_type;

endpackage

// ===== rtl/serial_frame_checker_core.sv =====
// Top level of the serial frame checker: input register, CSRs, frame check.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | sfc_req_type (rx_byte, chunk_end)
//   rsp     | out       | rsp_valid/rsp_stall | sfc_rsp_type (verdict, command, dispatch)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One byte per cycle sustained while rsp_stall is low; a verdict is offered once its chunk-end
// byte has passed the input register, then the result register.
// The per-byte CRC update is a fixed XOR network between the two registers.
// Synchronous reset loads the register defaults and clears the chunk state.
// rsp_stall holds the result; the input register then fills and raises req_stall.
module serial_frame_checker_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sfc_pkg::sfc_req_type          req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sfc_pkg::sfc_rsp_type          rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);
   import sfc_pkg::*;

   sfc_cfg_type cfg;
   sfc_req_type in_word_ff;
   logic        in_valid_ff, in_valid_in;
   logic        in_take;
   logic        req_accept;

   // Input register: holds one word until the check stage takes it
   assign req_stall  = in_valid_ff && !in_take;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)   in_valid_in = 1'b1;
      else if (in_take) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) in_word_ff <= req_word;
   end

   sfc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfc_frame_check u_check (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_word   (in_word_ff),
      .in_take   (in_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== rtl/sfc_csr.sv =====
// Configuration registers: markers and command limit.
module sfc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data,
   output sfc_pkg::sfc_cfg_type          cfg
);
   import sfc_pkg::*;

   sfc_cfg_type cfg_ff;
   sfc_cfg_type cfg_in;

   // Always able to take a write; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_START_MARKER:  cfg_in.start_marker  = csr_data;
            CSR_END_MARKER:    cfg_in.end_marker    = csr_data;
            CSR_COMMAND_LIMIT: cfg_in.command_limit = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_marker  <= START_MARKER_RST;
         cfg_ff.end_marker    <= END_MARKER_RST;
         cfg_ff.command_limit <= COMMAND_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/sfc_frame_check.sv =====
// Per-byte frame tracking, CRC update, verdict and result register.
module sfc_frame_check (
   input  logic                 clock,
   input  logic                 reset,
   input  sfc_pkg::sfc_cfg_type cfg,
   input  logic                 in_valid,
   input  sfc_pkg::sfc_req_type in_word,
   output logic                 in_take,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sfc_pkg::sfc_rsp_type rsp_word
);
   import sfc_pkg::*;

   localparam logic [POS_W-1:0] POS_FRAME   = POS_W'(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(PAYLOAD_BYTES);
   localparam logic [POS_W-1:0] POS_CRC_END = POS_W'(PAYLOAD_BYTES + CRC_BYTES);
   localparam logic [POS_W-1:0] POS_CMD     = POS_W'(CMD_OFFSET);
   localparam logic [POS_W-1:0] POS_MAX     = POS_W'(FRAME_BYTES + 1);

   // One byte as a 32-bit word, top 24 bits zero, MSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      logic        fb;
      c = crc;
      for (int k = 31; k >= 0; k--) begin
         fb = c[31] ^ ((k < 8) ? b[k[2:0]] : 1'b0);
         c  = {c[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
      end
      return c;
   endfunction

   logic [POS_W-1:0] pos_ff, pos_in, pos_next;
   logic [31:0]      crc_ff, crc_in, crc_next;
   logic [31:0]      rcrc_ff, rcrc_in, rcrc_next;
   logic [7:0]       cmd_ff, cmd_in, cmd_next;
   logic             mk_ff, mk_in, mk_next;
   logic             rsp_valid_ff, rsp_valid_in;
   sfc_rsp_type      rsp_ff, rsp_in;
   sfc_verdict_type  verdict;
   logic             in_frame;
   logic [7:0]       b;

   // Stage advances whenever the result register is free or draining
   assign in_take  = in_valid && (!rsp_valid_ff || !rsp_stall);
   assign b        = in_word.rx_byte;
   assign in_frame = pos_ff < POS_FRAME;

   // Fold this byte into the chunk state
   always_comb begin
      mk_next   = mk_ff;
      crc_next  = crc_ff;
      cmd_next  = cmd_ff;
      rcrc_next = rcrc_ff;
      if (in_frame) begin
         if (pos_ff == '0 && b != cfg.start_marker) mk_next = 1'b0;
         if (pos_ff == POS_LAST && b != cfg.end_marker) mk_next = 1'b0;
         if (pos_ff < POS_PAYLOAD) crc_next = crc_byte(crc_ff, b);
         if (pos_ff == POS_CMD) cmd_next = b;
         if (pos_ff >= POS_PAYLOAD && pos_ff < POS_CRC_END) rcrc_next = {rcrc_ff[23:0], b};
      end
      pos_next = (pos_ff <= POS_FRAME) ? pos_ff + 1'b1 : pos_ff;
   end

   // Verdict on the updated state
   always_comb begin
      if (pos_next > POS_FRAME)
         verdict = VERDICT_TOO_LONG;
      else if (pos_next < POS_FRAME || !mk_next)
         verdict = VERDICT_BAD_FMT;
      else if (crc_next != rcrc_next)
         verdict = VERDICT_CRC_BAD;
      else
         verdict = VERDICT_GOOD;
   end

   // Next state: chunk end clears for the next chunk
   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      rcrc_in      = rcrc_ff;
      cmd_in       = cmd_ff;
      mk_in        = mk_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (in_take) begin
         if (in_word.chunk_end) begin
            pos_in           = '0;
            crc_in           = CRC_INIT;
            rcrc_in          = '0;
            cmd_in           = '0;
            mk_in            = 1'b1;
            rsp_valid_in     = 1'b1;
            rsp_in.verdict   = verdict;
            rsp_in.command   = cmd_next;
            rsp_in.dispatch  = (verdict == VERDICT_GOOD) && (cmd_next < cfg.command_limit);
         end else begin
            pos_in  = pos_next;
            crc_in  = crc_next;
            rcrc_in = rcrc_next;
            cmd_in  = cmd_next;
            mk_in   = mk_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= CRC_INIT;
         rcrc_ff      <= '0;
         cmd_ff       <= '0;
         mk_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         rcrc_ff      <= rcrc_in;
         cmd_ff       <= cmd_in;
         mk_ff        <= mk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // A new result only ever follows a processed chunk-end byte
   a_rsp_from_chunk_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_take && in_word.chunk_end))
      else $error("result raised without a chunk-end byte");

   // Dispatch only on a good frame
   a_dispatch_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.dispatch |-> rsp_ff.verdict == VERDICT_GOOD)
      else $error("dispatch on a rejected frame");

   // Position saturates just past the frame length
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("byte position beyond saturation");

   // Chunk end leaves a clean state behind
   a_chunk_clear: assert property (@(posedge clock) disable iff (reset)
      in_take && in_word.chunk_end |=> pos_ff == '0 && mk_ff && crc_ff == CRC_INIT)
      else $error("chunk state not cleared");

endmodule
